// ===== rtl/bdda_pkg.sv =====
// Shared types, constants and calendar helpers for the business-day date advance block.
package bdda_pkg;

    // Field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int COUNT_W  = 10;
    localparam int WDAY_W   = 3;
    localparam int STAT_W   = 2;
    localparam int MASK_W   = 7;

    // Calendar limits
    localparam logic [YEAR_W-1:0]  YEAR_TOP   = 14'd9999;
    localparam logic [MASK_W-1:0]  MASK_ALL   = 7'h7F;
    localparam logic [MASK_W-1:0]  MASK_RESET = 7'd96;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [WDAY_W-1:0]  WDAY_SAT   = 3'd6;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    // Reciprocal constants: x/25 = (x*5243)>>17 for x < 4096, s/7 = (s*18725)>>17 for s < 2^15
    localparam logic [12:0] RECIP_25 = 13'd5243;
    localparam logic [14:0] RECIP_7  = 15'd18725;
    localparam int          RECIP_SH = 17;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;     // latch the input item
        logic              div;      // start year / 100 product
        logic              prep;     // finish year / 100, year mod 100
        logic              sum;      // weekday sum of the start date
        logic              chk;      // weekday mod 7, date check
        logic              step;     // move on by one day
        logic              capture;  // load the output register
        logic [STAT_W-1:0] st;       // status to capture
    } bdda_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic date_ok;   // start date is a valid Gregorian date
        logic finish;    // current date is the answer
        logic at_top;    // a step would pass 31/12/9999
    } bdda_sts_t;

    // Length of month m; zero for a month outside 1..12
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // (31*mm)/12 with mm the March-based month number
    function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] off;
        unique case (m)
            4'd1:    off = 5'd28;
            4'd2:    off = 5'd31;
            4'd3:    off = 5'd2;
            4'd4:    off = 5'd5;
            4'd5:    off = 5'd7;
            4'd6:    off = 5'd10;
            4'd7:    off = 5'd12;
            4'd8:    off = 5'd15;
            4'd9:    off = 5'd18;
            4'd10:   off = 5'd20;
            4'd11:   off = 5'd23;
            4'd12:   off = 5'd25;
            default: off = 5'd0;
        endcase
        return off;
    endfunction

endpackage

// ===== rtl/bdda_if.sv =====
// Valid/ready channel interfaces for the request, result and configuration ports.
interface bdda_req_if;
    import bdda_pkg::*;
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [COUNT_W-1:0] business_days;
    modport source (output valid, start_day, start_month, start_year, business_days,
                    input ready);
    modport sink   (input valid, start_day, start_month, start_year, business_days,
                    output ready);
endinterface

interface bdda_rsp_if;
    import bdda_pkg::*;
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
    logic [WDAY_W-1:0]  end_weekday;
    logic [STAT_W-1:0]  status;
    modport source (output valid, end_day, end_month, end_year, end_weekday, status,
                    input ready);
    modport sink   (input valid, end_day, end_month, end_year, end_weekday, status,
                    output ready);
endinterface

interface bdda_cfg_if;
    import bdda_pkg::*;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/business_day_date_advance.sv =====
// Top level of the business-day date advance block.
// Each request is worked one at a time: the setup states DIV, PREP, SUM and CHK find
// the start date's validity, its weekday and its year's leap phase, then the day stepper
// moves one calendar day per cycle until the count of business days is reached (or
// 31/12/9999 would be passed, as overflow), and the done state loads the result register
// once it is free. The default weekend is Friday/Saturday. An invalid start date goes
// straight from the date check to the result register.
// A new request is taken while the previous result still waits in the result register.
// Weekend mask writes take effect at once; a write of all ones is dropped.
module business_day_date_advance (
    input  logic        clk,
    input  logic        rst_n,
    bdda_req_if.sink    req,
    bdda_rsp_if.source  rsp,
    bdda_cfg_if.sink    cfg
);
    import bdda_pkg::*;

    bdda_cmd_t cmd;
    bdda_sts_t sts;

    assign cfg.ready = 1'b1;

    // Sequencer
    bdda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Calendar datapath
    bdda_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .start_day     (req.start_day),
        .start_month   (req.start_month),
        .start_year    (req.start_year),
        .business_days (req.business_days),
        .cfg_valid     (cfg.valid),
        .cfg_data      (cfg.data),
        .end_day       (rsp.end_day),
        .end_month     (rsp.end_month),
        .end_year      (rsp.end_year),
        .end_weekday   (rsp.end_weekday),
        .status        (rsp.status)
    );

`ifndef SYNTHESIS
    // A transfer in starts the sequence, so the request side closes next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while busy");

    // Status code is always a defined one
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.status == ST_OK || rsp.status == ST_INVALID ||
                       rsp.status == ST_OVERFLOW))
        else $error("undefined status code");

    // Invalid start dates report weekday zero
    a_invalid_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_INVALID) |-> (rsp.end_weekday == 3'd0))
        else $error("invalid date with nonzero weekday");

    // Good results have a nonzero day, a month in 1..12 and a weekday in 0..6
    a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_OK) |->
            (rsp.end_day != 5'd0 && rsp.end_month != 4'd0 &&
             rsp.end_month <= MONTH_DEC && rsp.end_weekday <= WDAY_SAT))
        else $error("malformed result date");
`endif

endmodule

// ===== rtl/bdda_ctrl.sv =====
// Controller state machine: sequences date check, weekday setup and day stepping.
module bdda_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  bdda_pkg::bdda_sts_t sts,
    output bdda_pkg::bdda_cmd_t cmd
);
    import bdda_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_RUN  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic              out_valid_reg, out_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.st         = st_reg;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.chk = 1'b1;
                if (sts.date_ok)
                begin
                    st_next    = ST_OK;
                    state_next = S_RUN;
                end
                else
                begin
                    st_next    = ST_INVALID;
                    state_next = S_DONE;
                end
            end
            S_RUN:
            begin
                priority if (sts.finish)
                begin
                    st_next    = ST_OK;
                    state_next = S_DONE;
                end
                else if (sts.at_top)
                begin
                    st_next    = ST_OVERFLOW;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            st_reg        <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/bdda_dp.sv =====
// Datapath: date registers, weekday setup arithmetic, day stepper, mask and result registers.
module bdda_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bdda_pkg::bdda_cmd_t          cmd,
    output bdda_pkg::bdda_sts_t          sts,
    input  logic [bdda_pkg::DAY_W-1:0]   start_day,
    input  logic [bdda_pkg::MONTH_W-1:0] start_month,
    input  logic [bdda_pkg::YEAR_W-1:0]  start_year,
    input  logic [bdda_pkg::COUNT_W-1:0] business_days,
    input  logic                         cfg_valid,
    input  logic [bdda_pkg::MASK_W-1:0]  cfg_data,
    output logic [bdda_pkg::DAY_W-1:0]   end_day,
    output logic [bdda_pkg::MONTH_W-1:0] end_month,
    output logic [bdda_pkg::YEAR_W-1:0]  end_year,
    output logic [bdda_pkg::WDAY_W-1:0]  end_weekday,
    output logic [bdda_pkg::STAT_W-1:0]  status
);
    import bdda_pkg::*;

    logic [DAY_W-1:0]   d_reg;
    logic [MONTH_W-1:0] m_reg;
    logic [YEAR_W-1:0]  y_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [24:0]        prod_reg;
    logic [7:0]         q_reg;      // year / 100
    logic [6:0]         c100_reg;   // year mod 100
    logic [1:0]         c4h_reg;    // (year / 100) mod 4
    logic [14:0]        sum_reg;
    logic [WDAY_W-1:0]  wd_reg;
    logic [MASK_W-1:0]  mask_reg;

    logic [DAY_W-1:0]   end_day_reg;
    logic [MONTH_W-1:0] end_month_reg;
    logic [YEAR_W-1:0]  end_year_reg;
    logic [WDAY_W-1:0]  end_weekday_reg;
    logic [STAT_W-1:0]  status_reg;

    logic               leap;
    logic [DAY_W-1:0]   dim;
    logic [7:0]         q_new;
    logic [YEAR_W-1:0]  rem100;
    logic               jan_feb;
    logic [YEAR_W-1:0]  yy;
    logic [7:0]         yq;
    logic [14:0]        sum_new;
    logic [29:0]        prod7;
    logic [12:0]        q7;
    logic [14:0]        r7;
    logic [7:0]         mask_ext;
    logic               off_day;
    logic               month_end;

    // Calendar of the current date
    assign leap = ((y_reg[1:0] == 2'd0) && (c100_reg != 7'd0)) ||
                  ((c100_reg == 7'd0) && (c4h_reg == 2'd0));
    assign dim  = days_in(m_reg, leap);

    // Year / 100 by reciprocal, and the remainder
    assign q_new  = prod_reg[RECIP_SH+7:RECIP_SH];
    assign rem100 = y_reg - YEAR_W'(q_new) * YEAR_W'(100);

    // Weekday sum on the March-based year
    assign jan_feb = (m_reg <= MONTH_FEB);
    assign yy      = y_reg - YEAR_W'(jan_feb);
    assign yq      = q_reg - 8'((jan_feb && (c100_reg == 7'd0)) ? 1 : 0);
    assign sum_new = 15'(d_reg) + 15'(yy) + 15'(yy >> 2) - 15'(yq) + 15'(yq >> 2)
                   + 15'(month_offset(m_reg));

    // Sum mod 7 by reciprocal
    assign prod7 = sum_reg * RECIP_7;
    assign q7    = prod7[RECIP_SH+12:RECIP_SH];
    assign r7    = sum_reg - 15'(q7) * 15'(7);

    // Day classification during stepping
    assign mask_ext  = {1'b0, mask_reg};
    assign off_day   = mask_ext[wd_reg];
    assign month_end = (d_reg >= dim);

    assign sts.date_ok = (y_reg >= 14'd1) && (y_reg <= YEAR_TOP) &&
                         (m_reg >= 4'd1) && (m_reg <= MONTH_DEC) &&
                         (d_reg >= 5'd1) && (d_reg <= dim);
    assign sts.finish  = !off_day && (cnt_reg <= 10'd1);
    assign sts.at_top  = month_end && (m_reg == MONTH_DEC) && (y_reg >= YEAR_TOP);

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg   <= start_day;
            m_reg   <= start_month;
            y_reg   <= start_year;
            cnt_reg <= business_days;
        end
        if (cmd.div)
        begin
            prod_reg <= 25'(y_reg >> 2) * 25'(RECIP_25);
        end
        if (cmd.prep)
        begin
            q_reg    <= q_new;
            c100_reg <= rem100[6:0];
            c4h_reg  <= q_new[1:0];
        end
        if (cmd.sum)
        begin
            sum_reg <= sum_new;
        end
        if (cmd.chk)
        begin
            wd_reg <= r7[WDAY_W-1:0];
        end
        // One calendar day forward
        if (cmd.step)
        begin
            if (!off_day && (cnt_reg != 10'd0))
            begin
                cnt_reg <= cnt_reg - 10'd1;
            end
            wd_reg <= (wd_reg == WDAY_SAT) ? 3'd0 : wd_reg + 3'd1;
            if (month_end)
            begin
                d_reg <= 5'd1;
                if (m_reg == MONTH_DEC)
                begin
                    m_reg <= 4'd1;
                    y_reg <= y_reg + 14'd1;
                    if (c100_reg == 7'd99)
                    begin
                        c100_reg <= 7'd0;
                        c4h_reg  <= c4h_reg + 2'd1;
                    end
                    else
                    begin
                        c100_reg <= c100_reg + 7'd1;
                    end
                end
                else
                begin
                    m_reg <= m_reg + 4'd1;
                end
            end
            else
            begin
                d_reg <= d_reg + 5'd1;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            end_day_reg     <= d_reg;
            end_month_reg   <= m_reg;
            end_year_reg    <= y_reg;
            end_weekday_reg <= (cmd.st == ST_INVALID) ? 3'd0 : wd_reg;
            status_reg      <= cmd.st;
        end
    end

    // Weekend mask; an all-ones write is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
        end
        else if (cfg_valid && (cfg_data != MASK_ALL))
        begin
            mask_reg <= cfg_data;
        end
    end

    assign end_day     = end_day_reg;
    assign end_month   = end_month_reg;
    assign end_year    = end_year_reg;
    assign end_weekday = end_weekday_reg;
    assign status      = status_reg;

endmodule
